// ===== rtl/core/fft_pkg.sv =====
package fft_pkg;

  localparam int MaxPoints = 64;
  localparam int MaxLog = 6;
  localparam int DataW = 22;
  localparam int SampleW = 16;
  localparam int IdxW = 6;
  localparam int LogW = 3;
  localparam logic [LogW-1:0] LogReset = 3'd6;
  localparam logic signed [DataW-1:0] LimHi = 22'sd2097151;
  localparam logic signed [DataW-1:0] LimLo = -22'sd2097152;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BF_RD,
    ST_BF_WR,
    ST_OUT
  } fft_state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       bf_read;
    logic       bf_write;
    logic       emit;
    logic [5:0] addr;
    logic [5:0] addr_b;
    logic [4:0] tw_k;
    logic       last;
  } fft_cmd_t;

  function automatic logic [15:0] quarter_cos(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0: v = 16'd32767;
      5'd1: v = 16'd32610;
      5'd2: v = 16'd32138;
      5'd3: v = 16'd31357;
      5'd4: v = 16'd30274;
      5'd5: v = 16'd28899;
      5'd6: v = 16'd27246;
      5'd7: v = 16'd25330;
      5'd8: v = 16'd23170;
      5'd9: v = 16'd20788;
      5'd10: v = 16'd18205;
      5'd11: v = 16'd15447;
      5'd12: v = 16'd12540;
      5'd13: v = 16'd9512;
      5'd14: v = 16'd6393;
      5'd15: v = 16'd3212;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [DataW-1:0] sat22(input logic signed [DataW:0] v);
    logic signed [DataW-1:0] r;
    if (v > 23'sd2097151) r = LimHi;
    else if (v < -23'sd2097152) r = LimLo;
    else r = v[DataW-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/fft_ctrl.sv =====
module fft_ctrl #(
  parameter int MAX_POINTS = fft_pkg::MaxPoints
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     cfg_write,
  input  logic [fft_pkg::LogW-1:0] log2_points,
  output logic                     busy,
  output fft_pkg::fft_cmd_t        cmd
);

  localparam int MaxLg = $clog2(MAX_POINTS);

  fft_pkg::fft_state_t state, state_next;
  logic [6:0] cnt, cnt_next;
  logic [2:0] stage, stage_next;
  logic [2:0] lg;
  logic [6:0] n;
  logic [5:0] half, bidx, ia, rev;

  always_comb begin
    lg = log2_points;
    if (lg < 3'd1) lg = 3'd1;
    if (lg > 3'(MaxLg)) lg = 3'(MaxLg);
    n = 7'd1 << lg;
  end

  // butterfly number cnt in stage: len = 2 << stage
  always_comb begin
    logic [5:0] lo;
    half = 6'd1 << stage;
    bidx = cnt[5:0];
    lo = bidx & (half - 6'd1);
    ia = ((bidx & ~(half - 6'd1)) << 1) | lo;
    rev = '0;
    for (int b = 0; b < fft_pkg::MaxLog; b++)
      if (3'(b) < lg) rev[lg - 3'd1 - 3'(b)] = cnt[b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fft_pkg::ST_LOAD;
      cnt <= '0;
      stage <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      stage <= stage_next;
    end
  end

  always_comb begin
    logic [5:0] lo2;
    state_next = state;
    cnt_next = cnt;
    stage_next = stage;
    busy = 1'b1;
    cmd = '0;
    lo2 = cnt[5:0] & (half - 6'd1);
    unique case (state)
      fft_pkg::ST_LOAD: begin
        busy = 1'b0;
        // sample words land in the work memory in bit-reversed order
        cmd.addr = rev;
        if (cfg_write) begin
          cnt_next = '0;
        end else if (start) begin
          cmd.load = 1'b1;
          if (cnt + 7'd1 >= n) begin
            cnt_next = '0;
            stage_next = '0;
            state_next = fft_pkg::ST_BF_RD;
          end else begin
            cnt_next = cnt + 7'd1;
          end
        end
      end
      fft_pkg::ST_BF_RD: begin
        cmd.bf_read = 1'b1;
        cmd.addr = ia;
        cmd.addr_b = ia + half;
        state_next = fft_pkg::ST_BF_WR;
      end
      fft_pkg::ST_BF_WR: begin
        cmd.bf_write = 1'b1;
        cmd.addr = ia;
        cmd.addr_b = ia + half;
        cmd.tw_k = 5'(lo2 << (3'd5 - stage));
        state_next = fft_pkg::ST_BF_RD;
        if (cnt + 7'd1 >= {1'b0, n[6:1]}) begin
          cnt_next = '0;
          if (stage + 3'd1 >= lg) state_next = fft_pkg::ST_OUT;
          else stage_next = stage + 3'd1;
        end else begin
          cnt_next = cnt + 7'd1;
        end
      end
      fft_pkg::ST_OUT: begin
        cmd.emit = 1'b1;
        cmd.addr = cnt[5:0];
        cmd.last = (cnt + 7'd1 >= n);
        if (cmd.last) begin
          cnt_next = '0;
          state_next = fft_pkg::ST_LOAD;
        end else begin
          cnt_next = cnt + 7'd1;
        end
      end
      default: state_next = fft_pkg::ST_LOAD;
    endcase
  end

endmodule

// ===== rtl/core/fft_dp.sv =====
module fft_dp #(
  parameter int MAX_POINTS = fft_pkg::MaxPoints
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fft_pkg::fft_cmd_t               cmd,
  input  logic signed [fft_pkg::SampleW-1:0] sample_real,
  input  logic signed [fft_pkg::SampleW-1:0] sample_imag,
  output logic signed [fft_pkg::DataW-1:0]   bin_real,
  output logic signed [fft_pkg::DataW-1:0]   bin_imag,
  output logic [fft_pkg::IdxW-1:0]           bin_index,
  output logic                               last_bin,
  output logic                               bin_valid
);

  localparam int W = fft_pkg::DataW;

  logic [2*W-1:0] wmem [MAX_POINTS];
  logic signed [W-1:0] ar, ai, br, bi;
  logic signed [15:0] wr, wi;
  logic signed [39:0] pr, pi_;
  logic signed [W:0] tr, ti;
  logic [2*W-1:0] a_new, b_new;

  // twiddle for k in 0..31
  always_comb begin
    logic [4:0] k;
    k = cmd.tw_k;
    if (k <= 5'd16) begin
      wr = $signed(fft_pkg::quarter_cos(k));
      wi = -$signed(fft_pkg::quarter_cos(5'd16 - k));
    end else begin
      wr = -$signed(fft_pkg::quarter_cos(5'd0 - k));
      wi = -$signed(fft_pkg::quarter_cos(k - 5'd16));
    end
  end

  always_comb begin
    pr = 40'(br * wr) - 40'(bi * wi) + 40'sd16384;
    pi_ = 40'(br * wi) + 40'(bi * wr) + 40'sd16384;
    tr = 23'(pr >>> 15);
    ti = 23'(pi_ >>> 15);
    a_new = {fft_pkg::sat22(23'(ar) + tr), fft_pkg::sat22(23'(ai) + ti)};
    b_new = {fft_pkg::sat22(23'(ar) - tr), fft_pkg::sat22(23'(ai) - ti)};
  end

  always_ff @(posedge clk) begin
    if (cmd.load)
      wmem[cmd.addr] <= {W'(sample_real), W'(sample_imag)};
    if (cmd.bf_read) begin
      {ar, ai} <= wmem[cmd.addr];
      {br, bi} <= wmem[cmd.addr_b];
    end
    if (cmd.bf_write) begin
      wmem[cmd.addr] <= a_new;
      wmem[cmd.addr_b] <= b_new;
    end
    if (cmd.emit) begin
      {bin_real, bin_imag} <= wmem[cmd.addr];
      bin_index <= cmd.addr;
      last_bin <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) bin_valid <= 1'b0;
    else bin_valid <= cmd.emit;
  end

endmodule

// ===== rtl/core/radix2_fft.sv =====
// radix-2 decimation-in-time fft, sizes 2 to MAX_POINTS
// input: a sample word is taken at a clock edge with start high, busy low and
//   cfg_valid low; it goes straight into the work memory at its bit-reversed address
// config: cfg_valid/cfg_ready write log2_points (always ready); a write
//   restarts the load count, so a partly loaded block is dropped
// output: bin_valid marks each bin for one cycle; the receiver cannot stall
// after the n-th sample: (n/2)*log2(n) butterflies on the one butterfly unit
//   (a read state, then a write back to the work memory), then n bins in
//   natural order, one a cycle
// busy is high from the cycle after the last sample until the final bin is
//   read from the work memory, and is low again while bin_valid marks it
// a block's samples are not taken while the previous block is still being
//   transformed or read out: the controller takes samples only in its load state
// reset: size 64, load count zero, no bins pending
module radix2_fft #(
  parameter int MAX_POINTS = fft_pkg::MaxPoints
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [fft_pkg::SampleW-1:0] sample_real,
  input  logic signed [fft_pkg::SampleW-1:0] sample_imag,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fft_pkg::LogW-1:0]           cfg_data,
  output logic                               bin_valid,
  output logic signed [fft_pkg::DataW-1:0]   bin_real,
  output logic signed [fft_pkg::DataW-1:0]   bin_imag,
  output logic [fft_pkg::IdxW-1:0]           bin_index,
  output logic                               last_bin
);

  logic [fft_pkg::LogW-1:0] log2_points;
  fft_pkg::fft_cmd_t cmd;
  logic cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) log2_points <= fft_pkg::LogReset;
    else if (cfg_write) log2_points <= cfg_data;
  end

  fft_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk, .rst, .start, .cfg_write, .log2_points, .busy, .cmd
  );

  fft_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk, .rst, .cmd, .sample_real, .sample_imag,
    .bin_real, .bin_imag, .bin_index, .last_bin, .bin_valid
  );

endmodule

// ===== rtl/core/radix2_fft_checker.sv =====
module radix2_fft_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       bin_valid,
  input logic [5:0] bin_index,
  input logic       last_bin
);

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    bin_valid && !last_bin |=> bin_valid && bin_index == $past(bin_index) + 6'd1)
    else $error("bin index not consecutive");

  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(bin_valid) |-> bin_index == 6'd0)
    else $error("first bin not zero");

  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    bin_valid && !last_bin |-> busy)
    else $error("bins emitted while idle");

  a_last_end: assert property (@(posedge clk) disable iff (rst)
    bin_valid && last_bin |=> !bin_valid)
    else $error("bins after last");

  // a word taken while loading is never followed straight away by a bin
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !bin_valid)
    else $error("bin right after a sample word");

endmodule

bind radix2_fft radix2_fft_checker u_chk (
  .clk, .rst, .start, .busy, .bin_valid, .bin_index, .last_bin
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

  typedef struct {
    logic signed [fft_pkg::DataW-1:0] re;
    logic signed [fft_pkg::DataW-1:0] im;
    logic [fft_pkg::IdxW-1:0]         idx;
    logic                             last;
  } bin_t;

  // holds the spectrum model and the queue of bins still to come
  class fft_scoreboard;
    int unsigned lg_reg;
    int unsigned fill;
    longint sre[fft_pkg::MaxPoints];
    longint sim[fft_pkg::MaxPoints];
    bin_t pending[$];
    int errors;

    function new();
      lg_reg = fft_pkg::LogReset;
      fill = 0;
      errors = 0;
    endfunction

    function void set_size(int unsigned v);
      lg_reg = v & 7;
      fill = 0;
    endfunction

    function longint rnd15(longint p);
      longint q;
      q = p + 16384;
      return q >>> 15;
    endfunction

    function longint clip22(longint v);
      if (v > 2097151) return 2097151;
      if (v < -2097152) return -2097152;
      return v;
    endfunction

    function void cos_sin(int unsigned k, output longint wr, output longint wi);
      longint qc[17] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                         23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
      k = k & 31;
      if (k <= 16) begin
        wr = qc[k];
        wi = -qc[16 - k];
      end else begin
        wr = -qc[32 - k];
        wi = -qc[k - 16];
      end
    endfunction

    function void spectrum(int unsigned lg);
      longint wre[fft_pkg::MaxPoints];
      longint wim[fft_pkg::MaxPoints];
      int unsigned n, r, len, half, base, m, ia, ib;
      longint wr, wi, tr, ti, ar, ai, br, bi;
      bin_t b;
      n = 1 << lg;
      for (int unsigned i = 0; i < n; i++) begin
        r = 0;
        for (int unsigned j = 0; j < lg; j++) r |= ((i >> j) & 1) << (lg - 1 - j);
        wre[r] = sre[i];
        wim[r] = sim[i];
      end
      for (len = 2; len <= n; len = len << 1) begin
        half = len >> 1;
        for (base = 0; base < n; base += len)
          for (m = 0; m < half; m++) begin
            ia = base + m;
            ib = ia + half;
            cos_sin(m * (64 / len), wr, wi);
            br = wre[ib];
            bi = wim[ib];
            tr = rnd15(br * wr - bi * wi);
            ti = rnd15(br * wi + bi * wr);
            ar = wre[ia];
            ai = wim[ia];
            wre[ia] = clip22(ar + tr);
            wim[ia] = clip22(ai + ti);
            wre[ib] = clip22(ar - tr);
            wim[ib] = clip22(ai - ti);
          end
      end
      for (int unsigned k = 0; k < n; k++) begin
        b.re = wre[k][fft_pkg::DataW-1:0];
        b.im = wim[k][fft_pkg::DataW-1:0];
        b.idx = k[fft_pkg::IdxW-1:0];
        b.last = (k == n - 1);
        pending.push_back(b);
      end
    endfunction

    function void note_sample(logic signed [15:0] re, logic signed [15:0] im);
      int unsigned lg;
      lg = lg_reg;
      if (lg < 1) lg = 1;
      if (lg > fft_pkg::MaxLog) lg = fft_pkg::MaxLog;
      if (fill >= (1 << lg)) fill = 0;
      sre[fill] = re;
      sim[fill] = im;
      fill++;
      if (fill == (1 << lg)) begin
        spectrum(lg);
        fill = 0;
      end
    endfunction

    function void check_bin(bin_t got);
      bin_t exp_b;
      if (pending.size() == 0) begin
        $error("unexpected bin index %0d", got.idx);
        errors++;
        return;
      end
      exp_b = pending.pop_front();
      if (got.re !== exp_b.re) begin
        $error("bin_real expected %0d got %0d", exp_b.re, got.re);
        errors++;
      end
      if (got.im !== exp_b.im) begin
        $error("bin_imag expected %0d got %0d", exp_b.im, got.im);
        errors++;
      end
      if (got.idx !== exp_b.idx) begin
        $error("bin_index expected %0d got %0d", exp_b.idx, got.idx);
        errors++;
      end
      if (got.last !== exp_b.last) begin
        $error("last_bin expected %0d got %0d", exp_b.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [fft_pkg::SampleW-1:0] sample_real = '0;
  logic signed [fft_pkg::SampleW-1:0] sample_imag = '0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [fft_pkg::LogW-1:0] cfg_data = '0;
  logic bin_valid;
  logic signed [fft_pkg::DataW-1:0] bin_real;
  logic signed [fft_pkg::DataW-1:0] bin_imag;
  logic [fft_pkg::IdxW-1:0] bin_index;
  logic last_bin;

  fft_scoreboard sb = new();
  longint cycles = 0;
  bit no_gaps = 0;
  int sent = 0;

  radix2_fft u_top (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    bin_t b;
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("status: fail");
      $finish;
    end
    if (!rst && bin_valid) begin
      b.re = bin_real;
      b.im = bin_imag;
      b.idx = bin_index;
      b.last = last_bin;
      sb.check_bin(b);
    end
  end

  // sends one sample word, with an optional idle burst first
  task automatic send_word(logic signed [15:0] re, logic signed [15:0] im);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1;
    sample_real <= re;
    sample_imag <= im;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_sample(re, im);
    sent++;
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    // a partial block leaves nothing pending; let any transform in flight finish
    repeat (700) @(posedge clk);
  endtask

  task automatic write_size(logic [fft_pkg::LogW-1:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.set_size(v);
  endtask

  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned sz;
    repeat (4) @(posedge clk);
    rst <= 0;
    // directed: default size with extreme words, then log2 sizes 1, 0, 7 and 2
    for (int i = 0; i < 64; i++)
      send_word((i % 2) ? 16'sh7fff : 16'sh8000, (i % 3) ? 16'sh8000 : 16'sh7fff);
    write_size(3'd1);
    send_word(16'sh7fff, 16'sh7fff);
    send_word(16'sh7fff, 16'sh7fff);
    send_word(16'sh8000, 16'sh8000);
    send_word(16'sh8000, 16'sh7fff);
    write_size(3'd0);
    send_word(16'sh1234, -16'sh4321);
    send_word(16'sh8000, 16'sh0001);
    write_size(3'd7);
    // partial block dropped by the next size write
    send_word(16'sh7fff, 16'sh0);
    send_word(16'sh0, 16'sh7fff);
    write_size(3'd2);
    for (int i = 0; i < 4; i++) send_word(16'sh7fff, 16'sh8000);
    // random phases across sizes, mostly small blocks
    while (sent < 350) begin
      sz = $urandom_range(0, 9);
      if (sz > 7) sz = $urandom_range(1, 4);
      write_size(sz[2:0]);
      if (sent > 280) no_gaps = 1;
      repeat ($urandom_range(1, 3) * (1 << ((sz < 1) ? 1 : (sz > 6) ? 6 : sz))
              + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0))
        send_word(rand_field(), rand_field());
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== radix2_fft.f =====
rtl/core/fft_pkg.sv
rtl/core/fft_ctrl.sv
rtl/core/fft_dp.sv
rtl/core/radix2_fft.sv
rtl/core/radix2_fft_checker.sv
bench/tb.sv
